// File: hw/rtl/dpcr_pkg.sv
`default_nettype none

package dpcr_pkg;

    localparam int SQ_STEPS  = 32;
    localparam int DV_STEPS  = 29;
    localparam int UNIT_BITS = 28;

    localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

    typedef struct packed {
        logic               respond;
        logic signed [31:0] apx;
        logic signed [31:0] apy;
        logic signed [31:0] avx;
        logic signed [31:0] avy;
        logic signed [31:0] bpx;
        logic signed [31:0] bpy;
        logic signed [31:0] bvx;
        logic signed [31:0] bvy;
        logic        [31:0] rsum;
        logic signed [32:0] dvx;
        logic signed [32:0] dvy;
    } t_base;

    typedef struct packed {
        t_base       base;
        logic        zero;
        logic        big;
        logic [4:0]  shl;
        logic        sx;
        logic        sy;
        logic [30:0] px;
        logic [30:0] py;
    } t_side;

    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] res;
        if (v > S32_MAX) begin
            res = 32'h7FFF_FFFF;
        end else if (v < S32_MIN) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/disc_pair_collision_resolve.sv
`default_nettype none

// Resolves one colliding pair of equal-mass discs per word: separates the
// centers to touching along the line of centers and swaps the normal parts
// of the velocities (Q16.16, saturated). A word with tuser clear passes
// through unchanged. Fully pipelined: one pair per cycle; between input
// accept and output valid lie 4 setup stages, 33 for the square root
// (one root bit per stage), 30 for the unit-vector divide (one quotient bit
// per stage) and 5 for the products and the final sums. When the output
// word is not taken the whole pipeline holds.
module disc_pair_collision_resolve
    import dpcr_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // a_pos_x, a_pos_y, a_vel_x, a_vel_y, a_radius(31),
    // b_pos_x, b_pos_y, b_vel_x, b_vel_y, b_radius(31), 2 pad bits
    input  wire logic [319:0] i_s_axis_tdata,
    // respond
    input  wire logic         i_s_axis_tuser,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // new_a_pos_x, new_a_pos_y, new_a_vel_x, new_a_vel_y,
    // new_b_pos_x, new_b_pos_y, new_b_vel_x, new_b_vel_y
    output logic [255:0]      o_m_axis_tdata
);

    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // ---- setup stages
    t_base in_base;
    logic signed [32:0] in_dx, in_dy;
    logic [30:0] in_ar, in_br;

    always_comb begin
        in_ar           = i_s_axis_tdata[158:128];
        in_br           = i_s_axis_tdata[317:287];
        in_base.respond = i_s_axis_tuser;
        in_base.apx     = i_s_axis_tdata[31:0];
        in_base.apy     = i_s_axis_tdata[63:32];
        in_base.avx     = i_s_axis_tdata[95:64];
        in_base.avy     = i_s_axis_tdata[127:96];
        in_base.bpx     = i_s_axis_tdata[190:159];
        in_base.bpy     = i_s_axis_tdata[222:191];
        in_base.bvx     = i_s_axis_tdata[254:223];
        in_base.bvy     = i_s_axis_tdata[286:255];
        in_base.rsum    = {1'b0, in_ar} + {1'b0, in_br};
        in_base.dvx     = $signed({in_base.bvx[31], in_base.bvx})
                        - $signed({in_base.avx[31], in_base.avx});
        in_base.dvy     = $signed({in_base.bvy[31], in_base.bvy})
                        - $signed({in_base.avy[31], in_base.avy});
        in_dx           = $signed({in_base.bpx[31], in_base.bpx})
                        - $signed({in_base.apx[31], in_base.apx});
        in_dy           = $signed({in_base.bpy[31], in_base.bpy})
                        - $signed({in_base.apy[31], in_base.apy});
    end

    logic               r_p1_vld, r_p2_vld, r_p3_vld, r_p4_vld;
    t_base              r_p1_base, r_p2_base;
    logic signed [32:0] r_p1_dx, r_p1_dy;
    logic [31:0]        r_p2_mx, r_p2_my;
    logic               r_p2_sx, r_p2_sy;
    t_side              r_p3_side, r_p4_side;
    logic [61:0]        r_p4_sqx, r_p4_sqy;

    logic [32:0] n_p2_mx, n_p2_my;
    logic [31:0] t_m;
    logic [4:0]  t_shl;
    t_side       n_p3_side;

    always_comb begin
        n_p2_mx = r_p1_dx[32] ? 33'(-r_p1_dx) : r_p1_dx;
        n_p2_my = r_p1_dy[32] ? 33'(-r_p1_dy) : r_p1_dy;
    end

    always_comb begin
        t_m   = (r_p2_mx > r_p2_my) ? r_p2_mx : r_p2_my;
        t_shl = '0;
        for (int b = 0; b < 31; b++) begin
            if (t_m[b]) begin
                t_shl = 5'(30 - b);
            end
        end
        n_p3_side.base = r_p2_base;
        n_p3_side.zero = (t_m == '0);
        n_p3_side.big  = t_m[31];
        n_p3_side.shl  = t_shl;
        n_p3_side.sx   = r_p2_sx;
        n_p3_side.sy   = r_p2_sy;
        n_p3_side.px   = t_m[31] ? r_p2_mx[31:1] : 31'(r_p2_mx[30:0] << t_shl);
        n_p3_side.py   = t_m[31] ? r_p2_my[31:1] : 31'(r_p2_my[30:0] << t_shl);
    end

    // ---- square root and divide
    logic [62:0] sq_sum;
    logic        sq_vld;
    logic [31:0] sq_root;
    t_side       sq_side;
    logic        dv_vld;
    logic [31:0] dv_root;
    logic [28:0] dv_qx, dv_qy;
    t_side       dv_side;

    assign sq_sum = {1'b0, r_p4_sqx} + {1'b0, r_p4_sqy};

    dpcr_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_p4_vld),
        .i_sum   (sq_sum),
        .i_side  (r_p4_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    dpcr_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (sq_vld),
        .i_root  (sq_root),
        .i_side  (sq_side),
        .o_vld   (dv_vld),
        .o_root  (dv_root),
        .o_qx    (dv_qx),
        .o_qy    (dv_qy),
        .o_side  (dv_side)
    );

    // ---- final stages
    logic [32:0]        t_dist;
    logic signed [34:0] n_f1_gap;
    logic signed [29:0] n_f1_ux, n_f1_uy;

    always_comb begin
        t_dist = dv_side.big ? {dv_root, 1'b0} : ({1'b0, dv_root} >> dv_side.shl);
        if (dv_side.zero) begin
            n_f1_gap = -$signed({3'b000, dv_side.base.rsum});
            n_f1_ux  = 30'sd1 <<< UNIT_BITS;
            n_f1_uy  = '0;
        end else begin
            n_f1_gap = $signed({2'b00, t_dist}) - $signed({3'b000, dv_side.base.rsum});
            n_f1_ux  = dv_side.sx ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
            n_f1_uy  = dv_side.sy ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
        end
    end

    logic               r_f1_vld, r_f2_vld, r_f3_vld, r_f4_vld;
    t_base              r_f1_base, r_f2_base, r_f3_base, r_f4_base;
    logic signed [29:0] r_f1_ux, r_f1_uy, r_f2_ux, r_f2_uy, r_f3_ux, r_f3_uy;
    logic signed [34:0] r_f1_gap;
    logic signed [64:0] r_f2_pgx, r_f2_pgy;
    logic signed [62:0] r_f2_pkx, r_f2_pky;
    logic signed [35:0] r_f3_k;
    logic [31:0]        r_f3_napx, r_f3_napy, r_f3_nbpx, r_f3_nbpy;
    logic [31:0]        r_f4_napx, r_f4_napy, r_f4_nbpx, r_f4_nbpy;
    logic signed [65:0] r_f4_kux, r_f4_kuy;
    logic               r_out_vld;
    logic [255:0]       r_out_data;

    logic signed [64:0] n_f2_pgx, n_f2_pgy;
    logic signed [62:0] n_f2_pkx, n_f2_pky;

    assign n_f2_pgx = r_f1_ux * r_f1_gap;
    assign n_f2_pgy = r_f1_uy * r_f1_gap;
    assign n_f2_pkx = r_f1_base.dvx * r_f1_ux;
    assign n_f2_pky = r_f1_base.dvy * r_f1_uy;

    logic signed [64:0] t_mvrx, t_mvry;
    logic signed [35:0] t_mvx, t_mvy;
    logic signed [63:0] t_ksum;

    always_comb begin
        t_mvrx = r_f2_pgx + 65'sd268435456;
        t_mvry = r_f2_pgy + 65'sd268435456;
        t_mvx  = t_mvrx[64:29];
        t_mvy  = t_mvry[64:29];
        t_ksum = 64'(r_f2_pkx) + 64'(r_f2_pky) + 64'sd134217728;
    end

    logic signed [65:0] n_f4_kux, n_f4_kuy;
    assign n_f4_kux = r_f3_k * r_f3_ux;
    assign n_f4_kuy = r_f3_k * r_f3_uy;

    logic signed [65:0] t_krx, t_kry;
    logic signed [37:0] t_kx, t_ky;
    logic [255:0]       n_out_data;

    always_comb begin
        t_krx = r_f4_kux + 66'sd134217728;
        t_kry = r_f4_kuy + 66'sd134217728;
        t_kx  = t_krx[65:28];
        t_ky  = t_kry[65:28];
        if (r_f4_base.respond) begin
            n_out_data = {
                sat32(64'($signed(r_f4_base.bvy)) - 64'(t_ky)),
                sat32(64'($signed(r_f4_base.bvx)) - 64'(t_kx)),
                r_f4_nbpy, r_f4_nbpx,
                sat32(64'($signed(r_f4_base.avy)) + 64'(t_ky)),
                sat32(64'($signed(r_f4_base.avx)) + 64'(t_kx)),
                r_f4_napy, r_f4_napx
            };
        end else begin
            n_out_data = {
                r_f4_base.bvy, r_f4_base.bvx, r_f4_base.bpy, r_f4_base.bpx,
                r_f4_base.avy, r_f4_base.avx, r_f4_base.apy, r_f4_base.apx
            };
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_p3_vld  <= 1'b0;
            r_p4_vld  <= 1'b0;
            r_f1_vld  <= 1'b0;
            r_f2_vld  <= 1'b0;
            r_f3_vld  <= 1'b0;
            r_f4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_p1_vld  <= i_s_axis_tvalid;
            r_p2_vld  <= r_p1_vld;
            r_p3_vld  <= r_p2_vld;
            r_p4_vld  <= r_p3_vld;
            r_f1_vld  <= dv_vld;
            r_f2_vld  <= r_f1_vld;
            r_f3_vld  <= r_f2_vld;
            r_f4_vld  <= r_f3_vld;
            r_out_vld <= r_f4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_base  <= in_base;
            r_p1_dx    <= in_dx;
            r_p1_dy    <= in_dy;
            r_p2_base  <= r_p1_base;
            r_p2_mx    <= n_p2_mx[31:0];
            r_p2_my    <= n_p2_my[31:0];
            r_p2_sx    <= r_p1_dx[32];
            r_p2_sy    <= r_p1_dy[32];
            r_p3_side  <= n_p3_side;
            r_p4_side  <= r_p3_side;
            r_p4_sqx   <= r_p3_side.px * r_p3_side.px;
            r_p4_sqy   <= r_p3_side.py * r_p3_side.py;
            r_f1_base  <= dv_side.base;
            r_f1_ux    <= n_f1_ux;
            r_f1_uy    <= n_f1_uy;
            r_f1_gap   <= n_f1_gap;
            r_f2_base  <= r_f1_base;
            r_f2_ux    <= r_f1_ux;
            r_f2_uy    <= r_f1_uy;
            r_f2_pgx   <= n_f2_pgx;
            r_f2_pgy   <= n_f2_pgy;
            r_f2_pkx   <= n_f2_pkx;
            r_f2_pky   <= n_f2_pky;
            r_f3_base  <= r_f2_base;
            r_f3_ux    <= r_f2_ux;
            r_f3_uy    <= r_f2_uy;
            r_f3_k     <= t_ksum[63:28];
            r_f3_napx  <= sat32(64'($signed(r_f2_base.apx)) + 64'(t_mvx));
            r_f3_napy  <= sat32(64'($signed(r_f2_base.apy)) + 64'(t_mvy));
            r_f3_nbpx  <= sat32(64'($signed(r_f2_base.bpx)) - 64'(t_mvx));
            r_f3_nbpy  <= sat32(64'($signed(r_f2_base.bpy)) - 64'(t_mvy));
            r_f4_base  <= r_f3_base;
            r_f4_kux   <= n_f4_kux;
            r_f4_kuy   <= n_f4_kuy;
            r_f4_napx  <= r_f3_napx;
            r_f4_napy  <= r_f3_napy;
            r_f4_nbpx  <= r_f3_nbpx;
            r_f4_nbpy  <= r_f3_nbpy;
            r_out_data <= n_out_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

`ifndef ASSERT_OFF
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/dpcr_sqrt_pipe.sv
`default_nettype none

module dpcr_sqrt_pipe
    import dpcr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire logic [62:0] i_sum,
    input  wire t_side       i_side,
    output logic             o_vld,
    output logic [31:0]      o_root,
    output t_side            o_side
);

    logic        r_vld  [0:SQ_STEPS];
    logic [62:0] r_rem  [0:SQ_STEPS];
    logic [63:0] r_root [0:SQ_STEPS];
    t_side       r_side [0:SQ_STEPS];

    logic [62:0] n_rem  [0:SQ_STEPS-1];
    logic [63:0] n_root [0:SQ_STEPS-1];
    logic [63:0] t_bit  [0:SQ_STEPS-1];
    logic [63:0] t_try  [0:SQ_STEPS-1];

    // one result bit per stage
    always_comb begin
        for (int j = 0; j < SQ_STEPS; j++) begin
            t_bit[j] = 64'd1 << (62 - 2 * j);
            t_try[j] = r_root[j] + t_bit[j];
            if ({1'b0, r_rem[j]} >= t_try[j]) begin
                n_rem[j]  = 63'({1'b0, r_rem[j]} - t_try[j]);
                n_root[j] = (r_root[j] >> 1) + t_bit[j];
            end else begin
                n_rem[j]  = r_rem[j];
                n_root[j] = r_root[j] >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= SQ_STEPS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int j = 0; j < SQ_STEPS; j++) begin
                r_vld[j+1] <= r_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= i_sum;
            r_root[0] <= '0;
            r_side[0] <= i_side;
            for (int j = 0; j < SQ_STEPS; j++) begin
                r_rem[j+1]  <= n_rem[j];
                r_root[j+1] <= n_root[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_vld  = r_vld[SQ_STEPS];
    assign o_root = r_root[SQ_STEPS][31:0];
    assign o_side = r_side[SQ_STEPS];

`ifndef ASSERT_OFF
    a_root_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && !o_side.zero |-> o_root >= 32'h4000_0000)
        else $error("normalized root below range");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/dpcr_div_pipe.sv
`default_nettype none

module dpcr_div_pipe
    import dpcr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_vld,
    input  wire logic [31:0] i_root,
    input  wire t_side       i_side,
    output logic             o_vld,
    output logic [31:0]      o_root,
    output logic [28:0]      o_qx,
    output logic [28:0]      o_qy,
    output t_side            o_side
);

    logic        r_vld  [0:DV_STEPS];
    logic [32:0] r_rx   [0:DV_STEPS];
    logic [32:0] r_ry   [0:DV_STEPS];
    logic [28:0] r_qx   [0:DV_STEPS];
    logic [28:0] r_qy   [0:DV_STEPS];
    logic [31:0] r_dv   [0:DV_STEPS];
    t_side       r_side [0:DV_STEPS];

    logic [32:0] t_shx [0:DV_STEPS-1];
    logic [32:0] t_shy [0:DV_STEPS-1];
    logic [32:0] n_rx  [0:DV_STEPS-1];
    logic [32:0] n_ry  [0:DV_STEPS-1];
    logic [28:0] n_qx  [0:DV_STEPS-1];
    logic [28:0] n_qy  [0:DV_STEPS-1];

    // restoring division, x and y lanes share the divisor
    always_comb begin
        for (int j = 0; j < DV_STEPS; j++) begin
            t_shx[j] = (j == 0) ? r_rx[j] : {r_rx[j][31:0], 1'b0};
            t_shy[j] = (j == 0) ? r_ry[j] : {r_ry[j][31:0], 1'b0};
            if (t_shx[j] >= {1'b0, r_dv[j]}) begin
                n_rx[j] = t_shx[j] - {1'b0, r_dv[j]};
                n_qx[j] = {r_qx[j][27:0], 1'b1};
            end else begin
                n_rx[j] = t_shx[j];
                n_qx[j] = {r_qx[j][27:0], 1'b0};
            end
            if (t_shy[j] >= {1'b0, r_dv[j]}) begin
                n_ry[j] = t_shy[j] - {1'b0, r_dv[j]};
                n_qy[j] = {r_qy[j][27:0], 1'b1};
            end else begin
                n_ry[j] = t_shy[j];
                n_qy[j] = {r_qy[j][27:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= DV_STEPS; j++) begin
                r_vld[j] <= 1'b0;
            end
        end else if (i_en) begin
            r_vld[0] <= i_vld;
            for (int j = 0; j < DV_STEPS; j++) begin
                r_vld[j+1] <= r_vld[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rx[0]   <= {2'b00, i_side.px};
            r_ry[0]   <= {2'b00, i_side.py};
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
            r_dv[0]   <= i_root;
            r_side[0] <= i_side;
            for (int j = 0; j < DV_STEPS; j++) begin
                r_rx[j+1]   <= n_rx[j];
                r_ry[j+1]   <= n_ry[j];
                r_qx[j+1]   <= n_qx[j];
                r_qy[j+1]   <= n_qy[j];
                r_dv[j+1]   <= r_dv[j];
                r_side[j+1] <= r_side[j];
            end
        end
    end

    assign o_vld  = r_vld[DV_STEPS];
    assign o_root = r_dv[DV_STEPS];
    assign o_qx   = r_qx[DV_STEPS];
    assign o_qy   = r_qy[DV_STEPS];
    assign o_side = r_side[DV_STEPS];

`ifndef ASSERT_OFF
    a_unit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld && !o_side.zero |-> o_qx <= 29'h1000_0000 && o_qy <= 29'h1000_0000)
        else $error("unit component above one");
`endif

endmodule

`default_nettype wire
